### rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants, types and helpers for the peak template canceller.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // Geometry
    localparam int TAPS        = 64;
    localparam int TAPS_W      = $clog2(TAPS);
    localparam int DATA_W      = 16;
    localparam int INDEX_W     = 6;
    localparam int LEN_W       = 7;
    localparam int FRAC_W      = 15;
    localparam int PROD_W      = 32;
    localparam int CELL_W      = 40;
    localparam int DIFF_W      = CELL_W - FRAC_W + 2;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

    // Output queue; deep enough to cover every word in flight at full rate
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1) + 1;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Sample word leaving the product stage
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] sample;
    } t_stage;

    // Result word leaving the cell stage
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] result;
        logic                     saturated;
    } t_result;

    // Add a product into a cell, clipping at the cell maximum
    function automatic logic [CELL_W-1:0] cell_add(input logic [CELL_W-1:0] cell_val,
                                                   input logic [PROD_W-1:0] prod_val);
        logic [CELL_W:0] sum;
        sum = {1'b0, cell_val} + (CELL_W + 1)'(prod_val);
        return sum[CELL_W] ? {CELL_W{1'b1}} : sum[CELL_W-1:0];
    endfunction

endpackage

### rtl/ptc_lanes.sv
// ----------------------------------------------------------------------------
// ptc_lanes
// Template store and one multiplier lane per tap; registers the products.
// ----------------------------------------------------------------------------
module ptc_lanes (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_word_valid,
    input  logic                                 i_cmd,
    input  logic signed [ptc_pkg::DATA_W-1:0]    i_sample,
    input  logic signed [ptc_pkg::DATA_W-1:0]    i_amp,
    input  logic        [ptc_pkg::INDEX_W-1:0]   i_index,
    input  logic        [ptc_pkg::DATA_W-1:0]    i_value,
    input  logic        [ptc_pkg::LEN_W-1:0]     i_length,
    output ptc_pkg::t_stage                      o_stage,
    output logic        [ptc_pkg::PROD_W-1:0]    o_prod [ptc_pkg::TAPS]
);

    logic [ptc_pkg::DATA_W-1:0]  r_tmpl [ptc_pkg::TAPS];
    logic [ptc_pkg::PROD_W-1:0]  r_prod [ptc_pkg::TAPS];
    logic [ptc_pkg::PROD_W-1:0]  n_prod [ptc_pkg::TAPS];
    ptc_pkg::t_stage             r_stage;
    ptc_pkg::t_stage             n_stage;
    logic [ptc_pkg::TAPS_W-1:0]  w_idx;
    logic                        w_load;
    logic                        w_peak;
    logic [ptc_pkg::PROD_W-1:0]  w_mag;

    assign w_idx  = ptc_pkg::TAPS_W'(i_index);
    assign w_load = i_word_valid && (i_cmd == ptc_pkg::CMD_LOAD)
                    && (32'(i_index) < ptc_pkg::TAPS);
    assign w_peak = (i_amp > 0);
    assign w_mag  = ptc_pkg::PROD_W'(i_amp[ptc_pkg::DATA_W-2:0]);

    // Write one template word on a load
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tmpl[w_idx] <= i_value;
        end
    end

    // Form each lane's product, zero outside the active length or without a peak
    always_comb begin
        for (int k = 0; k < ptc_pkg::TAPS; k++) begin
            if (w_peak && (32'(k) < 32'(i_length))) begin
                n_prod[k] = w_mag * ptc_pkg::PROD_W'(r_tmpl[k]);
            end else begin
                n_prod[k] = '0;
            end
        end
        n_stage.valid  = i_word_valid && (i_cmd == ptc_pkg::CMD_SAMPLE);
        n_stage.sample = i_sample;
    end

    // Hold the products for the cell stage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ptc_pkg::TAPS; k++) begin
            r_prod[k] <= n_prod[k];
        end
        r_stage.sample <= n_stage.sample;
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
    end

    assign o_stage = r_stage;
    assign o_prod  = r_prod;

endmodule

### rtl/ptc_cells.sv
// ----------------------------------------------------------------------------
// ptc_cells
// Transposed chain of cancel cells: accumulate, shift and form the result.
// ----------------------------------------------------------------------------
module ptc_cells (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptc_pkg::t_stage                   i_stage,
    input  logic [ptc_pkg::PROD_W-1:0]        i_prod [ptc_pkg::TAPS],
    output ptc_pkg::t_result                  o_res
);

    localparam logic signed [ptc_pkg::DIFF_W-1:0] RES_MAX =
        ptc_pkg::DIFF_W'((2 ** (ptc_pkg::DATA_W - 1)) - 1);
    localparam logic signed [ptc_pkg::DIFF_W-1:0] RES_MIN =
        ptc_pkg::DIFF_W'(-(2 ** (ptc_pkg::DATA_W - 1)));

    logic [ptc_pkg::CELL_W-1:0]          r_cell [ptc_pkg::TAPS];
    logic [ptc_pkg::CELL_W-1:0]          n_cell [ptc_pkg::TAPS];
    logic [ptc_pkg::CELL_W-1:0]          w_head;
    logic signed [ptc_pkg::DIFF_W-1:0]   w_diff;
    ptc_pkg::t_result                    r_res;
    ptc_pkg::t_result                    n_res;

    // Accumulate into each cell and shift one position towards the head
    always_comb begin
        w_head = ptc_pkg::cell_add(r_cell[0], i_prod[0]);
        for (int j = 0; j < ptc_pkg::TAPS - 1; j++) begin
            n_cell[j] = ptc_pkg::cell_add(r_cell[j + 1], i_prod[j + 1]);
        end
        n_cell[ptc_pkg::TAPS-1] = '0;
    end

    // Subtract the head cell from the sample and clip to 16 bits
    always_comb begin
        w_diff = ptc_pkg::DIFF_W'(i_stage.sample)
                 - signed'(ptc_pkg::DIFF_W'(w_head[ptc_pkg::CELL_W-1:ptc_pkg::FRAC_W]));
        n_res.valid = i_stage.valid;
        if (w_diff > RES_MAX) begin
            n_res.result    = RES_MAX[ptc_pkg::DATA_W-1:0];
            n_res.saturated = 1'b1;
        end else if (w_diff < RES_MIN) begin
            n_res.result    = RES_MIN[ptc_pkg::DATA_W-1:0];
            n_res.saturated = 1'b1;
        end else begin
            n_res.result    = w_diff[ptc_pkg::DATA_W-1:0];
            n_res.saturated = 1'b0;
        end
    end

    // Advance the cells on each sample word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ptc_pkg::TAPS; j++) begin
                r_cell[j] <= '0;
            end
        end else if (i_stage.valid) begin
            for (int j = 0; j < ptc_pkg::TAPS; j++) begin
                r_cell[j] <= n_cell[j];
            end
        end
    end

    // Register the result word
    always_ff @(posedge i_clk) begin
        r_res.result    <= n_res.result;
        r_res.saturated <= n_res.saturated;
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= n_res.valid;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/ptc_out_fifo.sv
// ----------------------------------------------------------------------------
// ptc_out_fifo
// Small result queue that absorbs output stalls while the pipeline runs on.
// ----------------------------------------------------------------------------
module ptc_out_fifo (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ptc_pkg::t_result                     i_push,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ptc_pkg::DATA_W-1:0]    o_result,
    output logic                                 o_saturated,
    output logic [ptc_pkg::FIFO_CNT_W-1:0]       o_count
);

    logic signed [ptc_pkg::DATA_W-1:0]  r_data [ptc_pkg::FIFO_DEPTH];
    logic                               r_sat  [ptc_pkg::FIFO_DEPTH];
    logic [ptc_pkg::FIFO_PTR_W-1:0]     r_wr_ptr;
    logic [ptc_pkg::FIFO_PTR_W-1:0]     r_rd_ptr;
    logic [ptc_pkg::FIFO_CNT_W-1:0]     r_count;
    logic                               w_pop;

    assign w_pop = (r_count != '0) && i_ready;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data[r_wr_ptr] <= i_push.result;
            r_sat[r_wr_ptr]  <= i_push.saturated;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push.valid, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid     = (r_count != '0);
    assign o_result    = r_data[r_rd_ptr];
    assign o_saturated = r_sat[r_rd_ptr];
    assign o_count     = r_count;

endmodule

### rtl/peak_template_canceller_top.sv
// ----------------------------------------------------------------------------
// peak_template_canceller_top
// Removes a stored peak shape from a sample stream with a transposed FIR.
// ----------------------------------------------------------------------------
// A sample word passes through the input, product and result registers and then
// the output queue on its way to the output.
// Throughput: one word per cycle; the input stalls only once the 8-word queue
// holds everything in flight. Load words give no result.
// Reset clears the cancel cells and queue at once and sets the length to 64;
// the template store holds whatever it held until written.
module peak_template_canceller_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ptc_pkg::LEN_W-1:0]            i_cfg_template_length,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_cmd,
    input  logic signed [ptc_pkg::DATA_W-1:0]    i_sample,
    input  logic signed [ptc_pkg::DATA_W-1:0]    i_peak_amplitude,
    input  logic        [ptc_pkg::INDEX_W-1:0]   i_template_index,
    input  logic        [ptc_pkg::DATA_W-1:0]    i_template_value,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [ptc_pkg::DATA_W-1:0]    o_result,
    output logic                                 o_saturated
);

    logic [ptc_pkg::LEN_W-1:0]           r_length;
    logic                                r_in_valid;
    logic                                r_in_cmd;
    logic signed [ptc_pkg::DATA_W-1:0]   r_in_sample;
    logic signed [ptc_pkg::DATA_W-1:0]   r_in_amp;
    logic        [ptc_pkg::INDEX_W-1:0]  r_in_index;
    logic        [ptc_pkg::DATA_W-1:0]   r_in_value;
    logic                                w_accept;
    logic [ptc_pkg::FIFO_CNT_W-1:0]      w_fifo_count;
    logic [ptc_pkg::FIFO_CNT_W-1:0]      w_in_flight;
    ptc_pkg::t_stage                     w_stage;
    ptc_pkg::t_result                    w_res;
    logic [ptc_pkg::PROD_W-1:0]          w_prod [ptc_pkg::TAPS];

    assign o_cfg_ready = 1'b1;

    // Hold the template length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= ptc_pkg::LEN_RESET;
        end else if (i_cfg_valid) begin
            r_length <= i_cfg_template_length;
        end
    end

    // Admit a word only while the queue has room for everything in flight
    assign w_in_flight = w_fifo_count
                         + ptc_pkg::FIFO_CNT_W'(r_in_valid)
                         + ptc_pkg::FIFO_CNT_W'(w_stage.valid)
                         + ptc_pkg::FIFO_CNT_W'(w_res.valid);
    assign o_in_ready  = (32'(w_in_flight) < ptc_pkg::FIFO_DEPTH);
    assign w_accept    = i_in_valid && o_in_ready;

    // Register the accepted word
    always_ff @(posedge i_clk) begin
        r_in_cmd    <= i_cmd;
        r_in_sample <= i_sample;
        r_in_amp    <= i_peak_amplitude;
        r_in_index  <= i_template_index;
        r_in_value  <= i_template_value;
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    ptc_lanes u_lanes (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (r_in_valid),
        .i_cmd        (r_in_cmd),
        .i_sample     (r_in_sample),
        .i_amp        (r_in_amp),
        .i_index      (r_in_index),
        .i_value      (r_in_value),
        .i_length     (r_length),
        .o_stage      (w_stage),
        .o_prod       (w_prod)
    );

    ptc_cells u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage),
        .i_prod  (w_prod),
        .o_res   (w_res)
    );

    ptc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_result    (o_result),
        .o_saturated (o_saturated),
        .o_count     (w_fifo_count)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the peak template canceller. A short table of
// directed words runs first (extremes, loads, length changes), then phases
// of random sample and load words, each phase first writing a template length.
// Every accepted sample word is run through a local model of the cancel
// cells. Each output word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY      = 4;
    localparam int SETTLE_WAIT  = 3 * LATENCY;
    localparam int LONG_HOLD    = 80;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int PRED_DEPTH   = 256;
    localparam longint unsigned CELL_LIMIT = (64'd1 << ptc_pkg::CELL_W) - 64'd1;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_LOAD,
        ROW_LENGTH
    } t_row_kind;

    typedef struct packed {
        t_row_kind                         kind;
        logic signed [ptc_pkg::DATA_W-1:0] samp;
        logic signed [ptc_pkg::DATA_W-1:0] amp;
        logic [ptc_pkg::INDEX_W-1:0]       idx;
        logic [ptc_pkg::DATA_W-1:0]        value;
        logic [ptc_pkg::LEN_W-1:0]         len;
        logic                              typed;
        logic signed [ptc_pkg::DATA_W-1:0] exp_result;
        logic                              exp_sat;
    } t_plan_row;

    typedef struct packed {
        logic signed [ptc_pkg::DATA_W-1:0] result;
        logic                              saturated;
    } t_cancel_word;

    // Directed plan; typed expectations only where the cells are known empty
    localparam int NUM_ROWS = 24;
    localparam t_plan_row PLAN [NUM_ROWS] = '{
        // no peaks straight after reset: output equals input
        '{ROW_SAMPLE, 16'h0000, 16'h0000, 6'd0,  16'h0000, 7'd0, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h7FFF, 16'h0000, 6'd0,  16'h0000, 7'd0, 1'b1, 16'h7FFF, 1'b0},
        '{ROW_SAMPLE, 16'h8000, 16'h8000, 6'd0,  16'h0000, 7'd0, 1'b1, 16'h8000, 1'b0},
        '{ROW_SAMPLE, 16'hFFFF, 16'hFFFF, 6'd0,  16'h0000, 7'd0, 1'b1, 16'hFFFF, 1'b0},
        '{ROW_SAMPLE, 16'h1234, 16'h0000, 6'h3F, 16'hFFFF, 7'd0, 1'b1, 16'h1234, 1'b0},
        // short template: unity, zero, above unity, half
        '{ROW_LENGTH, 16'h0000, 16'h0000, 6'd0,  16'h0000, 7'd4, 1'b0, 16'h0000, 1'b0},
        '{ROW_LOAD,   16'hFFFF, 16'h7FFF, 6'd0,  16'h8000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_LOAD,   16'h0000, 16'h0000, 6'd1,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_LOAD,   16'h0000, 16'h0000, 6'd2,  16'hFFFF, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_LOAD,   16'h0000, 16'h0000, 6'd3,  16'h4000, 7'd0, 1'b0, 16'h0000, 1'b0},
        // largest peak, then a clip towards the negative rail
        '{ROW_SAMPLE, 16'h0064, 16'h7FFF, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h8000, 16'h7FFF, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0000, 16'h0000, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0000, 16'h0001, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h8000, 16'h0000, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h7FFF, 16'h7FFF, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        // single tap, with cells from the longer template still draining
        '{ROW_LENGTH, 16'h0000, 16'h0000, 6'd0,  16'h0000, 7'd1, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0005, 16'h4E20, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        // zero length: peaks add nothing
        '{ROW_LENGTH, 16'h0000, 16'h0000, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h0007, 16'h7FFF, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_LOAD,   16'h5555, 16'hAAAA, 6'h3F, 16'h0001, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_LENGTH, 16'h0000, 16'h0000, 6'd0,  16'h0000, 7'd2, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h7FFF, 16'h7FFF, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_SAMPLE, 16'h8000, 16'h8000, 6'd0,  16'h0000, 7'd0, 1'b0, 16'h0000, 1'b0}
    };

    localparam logic [ptc_pkg::LEN_W-1:0] FIXED_LEN [NUM_PHASES] = '{
        7'd127, 7'd1, 7'd0, 7'd64, 7'd0, 7'd0, 7'd0, 7'd64
    };

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic [ptc_pkg::LEN_W-1:0]            i_cfg_template_length;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic                                 i_cmd;
    logic signed [ptc_pkg::DATA_W-1:0]    i_sample;
    logic signed [ptc_pkg::DATA_W-1:0]    i_peak_amplitude;
    logic [ptc_pkg::INDEX_W-1:0]          i_template_index;
    logic [ptc_pkg::DATA_W-1:0]           i_template_value;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic signed [ptc_pkg::DATA_W-1:0]    o_result;
    logic                                 o_saturated;

    // Local copy of the block state
    logic [ptc_pkg::DATA_W-1:0]           tmpl_words  [ptc_pkg::TAPS];
    logic [ptc_pkg::CELL_W-1:0]           cancel_cell [ptc_pkg::TAPS];
    logic [ptc_pkg::TAPS_W-1:0]           head_idx;
    logic [ptc_pkg::LEN_W-1:0]            tap_count;

    // Predicted output words, oldest at the read index
    t_cancel_word                         pred_mem [PRED_DEPTH];
    int                                   pred_wr;
    int                                   pred_rd;
    int                                   mismatch_count;
    int                                   cycle_count;
    bit                                   quiet;
    bit                                   hold_req;

    peak_template_canceller_top u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_template_length (i_cfg_template_length),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_cmd                 (i_cmd),
        .i_sample              (i_sample),
        .i_peak_amplitude      (i_peak_amplitude),
        .i_template_index      (i_template_index),
        .i_template_value      (i_template_value),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_result              (o_result),
        .o_saturated           (o_saturated)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("peak_template_canceller_top verification failed");
            $finish;
        end
    end

    // Add the peak into the cells ahead, then drain the head cell
    task automatic cancel_sample(input logic signed [ptc_pkg::DATA_W-1:0] samp,
                                 input logic signed [ptc_pkg::DATA_W-1:0] amp,
                                 output t_cancel_word word);
        int unsigned     taps_used;
        int unsigned     k;
        int unsigned     pos;
        longint unsigned total;
        longint          diff;
        word.saturated = 1'b0;
        if (amp > 0) begin
            taps_used = (tap_count > ptc_pkg::TAPS) ? ptc_pkg::TAPS : tap_count;
            for (k = 0; k < taps_used; k++) begin
                pos   = (head_idx + k) % ptc_pkg::TAPS;
                total = longint'(cancel_cell[pos])
                      + longint'(unsigned'(amp)) * longint'(tmpl_words[k]);
                cancel_cell[pos] = (total > CELL_LIMIT) ? ptc_pkg::CELL_W'(CELL_LIMIT)
                                                        : total[ptc_pkg::CELL_W-1:0];
            end
        end
        diff = longint'(samp) - longint'(cancel_cell[head_idx] >> ptc_pkg::FRAC_W);
        if (diff > 32767) begin
            diff = 32767;
            word.saturated = 1'b1;
        end else if (diff < -32768) begin
            diff = -32768;
            word.saturated = 1'b1;
        end
        word.result = ptc_pkg::DATA_W'(diff);
        cancel_cell[head_idx] = '0;
        head_idx = head_idx + 1'b1;
    endtask

    // Offer one word and hold it until accepted; valid stays high afterwards
    task automatic send_word(input logic                              cmd,
                             input logic signed [ptc_pkg::DATA_W-1:0] samp,
                             input logic signed [ptc_pkg::DATA_W-1:0] amp,
                             input logic [ptc_pkg::INDEX_W-1:0]       idx,
                             input logic [ptc_pkg::DATA_W-1:0]        value,
                             input logic                              typed,
                             input t_cancel_word                      typed_word);
        t_cancel_word predicted;
        @(negedge i_clk);
        i_in_valid       = 1'b1;
        i_cmd            = cmd;
        i_sample         = samp;
        i_peak_amplitude = amp;
        i_template_index = idx;
        i_template_value = value;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (cmd == ptc_pkg::CMD_LOAD) begin
            tmpl_words[idx] = value;
        end else begin
            cancel_sample(samp, amp, predicted);
            pred_mem[pred_wr % PRED_DEPTH] = typed ? typed_word : predicted;
            pred_wr++;
        end
    endtask

    // Drop valid for a number of cycles
    task automatic idle_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // Hold the input until every predicted word has come out
    task automatic wait_results();
        idle_input(1);
        while (pred_wr != pred_rd) @(posedge i_clk);
    endtask

    // Write the template length with the block idle
    task automatic write_length(input logic [ptc_pkg::LEN_W-1:0] len);
        wait_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid           = 1'b1;
        i_cfg_template_length = len;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tap_count = len;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Output ready: random stalls, one long hold-off on request
    initial begin : sink
        int stall_left;
        int run_left;
        stall_left  = 0;
        run_left    = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if (run_left > 0) begin
                i_out_ready = 1'b1;
                run_left--;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                i_out_ready = 1'b0;
                stall_left  = LONG_HOLD - 1;
            end else if (quiet) begin
                i_out_ready = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready = 1'b0;
                stall_left  = $urandom_range(1, 6) - 1;
            end else begin
                i_out_ready = 1'b1;
                run_left    = $urandom_range(0, 12);
            end
        end
    end

    // Check each output word against the oldest prediction
    always @(posedge i_clk) begin
        t_cancel_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pred_wr == pred_rd) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected output word: result %0d sat %0b",
                             o_result, o_saturated);
            end else begin
                want = pred_mem[pred_rd % PRED_DEPTH];
                pred_rd++;
                if (o_result !== want.result || o_saturated !== want.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: expected result %0d sat %0b, got %0d sat %0b",
                                 want.result, want.saturated, o_result, o_saturated);
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int                                r;
        int                                p;
        int                                n;
        int                                pick;
        logic signed [ptc_pkg::DATA_W-1:0] amp;
        logic [ptc_pkg::DATA_W-1:0]        value;
        logic [ptc_pkg::LEN_W-1:0]         len;
        t_cancel_word                      typed_word;

        i_rst_n               = 1'b0;
        i_cfg_valid           = 1'b0;
        i_cfg_template_length = '0;
        i_in_valid            = 1'b0;
        i_cmd                 = ptc_pkg::CMD_SAMPLE;
        i_sample              = '0;
        i_peak_amplitude      = '0;
        i_template_index      = '0;
        i_template_value      = '0;
        pred_wr               = 0;
        pred_rd               = 0;
        mismatch_count        = 0;
        cycle_count           = 0;
        quiet                 = 1'b0;
        hold_req              = 1'b0;
        head_idx              = '0;
        tap_count             = ptc_pkg::LEN_RESET;
        for (r = 0; r < ptc_pkg::TAPS; r++) begin
            tmpl_words[r]  = '0;
            cancel_cell[r] = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed plan
        for (r = 0; r < NUM_ROWS; r++) begin
            if ($urandom_range(0, 4) == 0)
                idle_input($urandom_range(1, 6));
            typed_word.result    = PLAN[r].exp_result;
            typed_word.saturated = PLAN[r].exp_sat;
            case (PLAN[r].kind)
                ROW_LENGTH: begin
                    write_length(PLAN[r].len);
                end
                ROW_LOAD: begin
                    send_word(ptc_pkg::CMD_LOAD, PLAN[r].samp, PLAN[r].amp, PLAN[r].idx,
                              PLAN[r].value, 1'b0, typed_word);
                end
                default: begin
                    send_word(ptc_pkg::CMD_SAMPLE, PLAN[r].samp, PLAN[r].amp, PLAN[r].idx,
                              PLAN[r].value, PLAN[r].typed, typed_word);
                end
            endcase
        end

        // Fill the whole template so any length may be used from here on
        for (r = 0; r < ptc_pkg::TAPS; r++) begin
            value = ($urandom_range(0, 5) == 0) ? ptc_pkg::DATA_W'($urandom)
                                                : ptc_pkg::DATA_W'($urandom_range(0, 32768));
            send_word(ptc_pkg::CMD_LOAD, ptc_pkg::DATA_W'($urandom),
                      ptc_pkg::DATA_W'($urandom), ptc_pkg::INDEX_W'(r),
                      value, 1'b0, typed_word);
        end

        // Random phases, one template length each; the last runs without idling
        for (p = 0; p < NUM_PHASES; p++) begin
            len = (p >= 4 && p <= 6) ? ptc_pkg::LEN_W'($urandom_range(2, 63))
                                     : FIXED_LEN[p];
            quiet = (p == NUM_PHASES - 1);
            write_length(len);
            if (p == 1)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == PHASE_ITEMS / 2)
                    wait_results();
                if (!quiet && $urandom_range(0, 4) == 0)
                    idle_input($urandom_range(1, 6));
                pick = $urandom_range(0, 19);
                if (pick < 3) begin
                    value = ($urandom_range(0, 5) == 0)
                            ? ptc_pkg::DATA_W'($urandom)
                            : ptc_pkg::DATA_W'($urandom_range(0, 32768));
                    send_word(ptc_pkg::CMD_LOAD, ptc_pkg::DATA_W'($urandom),
                              ptc_pkg::DATA_W'($urandom), ptc_pkg::INDEX_W'($urandom),
                              value, 1'b0, typed_word);
                end else begin
                    if (pick < 10)
                        amp = ($urandom_range(0, 3) == 0) ? '0 : {1'b1, 15'($urandom)};
                    else if (pick < 15)
                        amp = ptc_pkg::DATA_W'($urandom_range(1, 2047));
                    else
                        amp = ptc_pkg::DATA_W'($urandom_range(1, 32767));
                    send_word(ptc_pkg::CMD_SAMPLE, ptc_pkg::DATA_W'($urandom), amp,
                              ptc_pkg::INDEX_W'($urandom), ptc_pkg::DATA_W'($urandom),
                              1'b0, typed_word);
                end
            end
        end

        // Drain, then let the pipeline settle
        wait_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("peak_template_canceller_top verification clean");
        else
            $display("peak_template_canceller_top verification failed");
        $finish;
    end

endmodule
